>>> sv/hts_pkg.sv
// hts_pkg: shared types, constants and the crc helper for the huffman stream decoder
// used by hts_front, hts_core and huffman_tree_stream_decoder
`default_nettype none
package hts_pkg;

   // storage sizes (node store and pending stack depths are powers of two)
   localparam int NODE_COUNT  = 512;
   localparam int STACK_DEPTH = 256;
   localparam int NODE_AW     = $clog2(NODE_COUNT);
   localparam int NFN_W       = $clog2(NODE_COUNT + 1);
   localparam int STK_AW      = $clog2(STACK_DEPTH);
   localparam int SP_W        = $clog2(STACK_DEPTH + 1);
   // node word: leaf flag over a 10-bit payload (child index or byte)
   localparam int NODE_W      = 11;
   localparam int LEAF_POS    = 10;
   localparam int QDEPTH      = 2;
   localparam logic [15:0] CRC_POLY = 16'h1021;

   // function codes of an input item
   localparam logic [1:0] FN_COMP = 2'd0;
   localparam logic [1:0] FN_RAW  = 2'd1;
   localparam logic [1:0] FN_DATA = 2'd2;
   localparam logic [1:0] FN_NONE = 2'd3;

   typedef struct packed {
      logic [1:0] func;
      logic [7:0] data_byte;
   } req_type;

   typedef struct packed {
      logic [7:0]  out_byte;
      logic [15:0] running_crc;
      logic        error;
      logic        last;
   } rsp_type;

   typedef enum logic [1:0] {
      PH_RAW, PH_BUILD, PH_DECODE, PH_HALT
   } phase_type;

   typedef enum logic [2:0] {
      ST_FETCH, ST_BUILD, ST_POP, ST_ROOT, ST_ROOT_WAIT, ST_DEC, ST_DEC_CHK, ST_FLUSH
   } state_type;

   // crc-16 update by one byte, msb first
   function automatic logic [15:0] crc_next(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {b, 8'h00};
      for (int i = 0; i < 8; i++) begin
         if (c[15]) c = {c[14:0], 1'b0} ^ CRC_POLY;
         else c = {c[14:0], 1'b0};
      end
      return c;
   endfunction

endpackage
`default_nettype wire

>>> sv/hts_front.sv
// hts_front: input side, drops unused codes and queues items for the core
// depends on hts_pkg
`default_nettype none
module hts_front (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_valid,
   output logic                 req_stall,
   input  wire hts_pkg::req_type req_item,
   output logic                 q_valid,
   output hts_pkg::req_type     q_item,
   input  wire logic            q_pop
);
   import hts_pkg::*;

   localparam int QAW = $clog2(QDEPTH);

   req_type          q_mem [QDEPTH];
   logic [QAW-1:0]   wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [QAW:0]     count_ff, count_in;
   logic             push;

   // accept while there is room; unused codes are taken and dropped
   assign req_stall = (count_ff == (QAW+1)'(QDEPTH));
   assign push      = req_valid && !req_stall && (req_item.func != FN_NONE);
   assign q_valid   = (count_ff != '0);
   assign q_item    = q_mem[rd_ptr_ff];

   // pointer and fill update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) wr_ptr_in = (wr_ptr_ff == QAW'(QDEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      if (q_pop) rd_ptr_in = (rd_ptr_ff == QAW'(QDEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      if (push && !q_pop) count_in = count_ff + 1'b1;
      else if (!push && q_pop) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // queue storage
   always_ff @(posedge clock) begin
      if (push) q_mem[wr_ptr_ff] <= req_item;
   end

   no_pop_when_empty: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_valid) else $error("pop from empty queue");
   fill_in_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= (QAW+1)'(QDEPTH)) else $error("queue fill out of range");
   full_blocks_push: assert property (@(posedge clock) disable iff (reset)
      (count_ff == (QAW+1)'(QDEPTH)) && !q_pop |=> count_ff == (QAW+1)'(QDEPTH))
      else $error("queue overrun");

endmodule
`default_nettype wire

>>> sv/hts_core.sv
// hts_core: tree build, tree walk, crc and result ordering
// depends on hts_pkg; items arrive from hts_front
`default_nettype none
module hts_core (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             q_valid,
   input  wire hts_pkg::req_type q_item,
   output logic                  q_pop,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output hts_pkg::rsp_type      rsp_item
);
   import hts_pkg::*;

   state_type          state_ff, state_in;
   phase_type          phase_ff, phase_in;
   logic [SP_W-1:0]    sp_ff, sp_in;
   logic [NFN_W-1:0]   nfn_ff, nfn_in;
   logic [3:0]         lbl_ff, lbl_in;
   logic [7:0]         acc_ff, acc_in;
   logic [NODE_AW-1:0] walk_ff, walk_in;
   logic [NODE_AW-1:0] child_ff, child_in;
   logic [NODE_W-1:0]  cur_ff, cur_in, root_ff, root_in;
   logic [15:0]        crc_ff, crc_in;
   logic               err_ff, err_in;
   logic [7:0]         data_ff, data_in;
   logic [3:0]         cnt_ff, cnt_in;
   logic               pend_v_ff, pend_v_in;
   rsp_type            pend_ff, pend_in;
   logic               out_v_ff, out_v_in;
   rsp_type            out_ff, out_in;

   logic [NODE_W-1:0]  node_mem [NODE_COUNT];
   logic [NODE_AW-1:0] stk_mem [STACK_DEPTH];
   logic [NODE_W-1:0]  node_rd_ff;
   logic [NODE_AW-1:0] stk_rd_ff;
   logic               node_we, node_re, stk_we, stk_re;
   logic [NODE_AW-1:0] node_wa, node_ra;
   logic [NODE_W-1:0]  node_wd;
   logic [STK_AW-1:0]  stk_wa, stk_ra;
   logic [NODE_AW-1:0] stk_wd;

   logic               out_free, bit_cur;
   logic [3:0]         cnt_dec;
   logic [7:0]         acc_new;
   logic [15:0]        crc_upd;
   state_type          after_bit;

   assign rsp_valid = out_v_ff;
   assign rsp_item  = out_ff;

   // sequencer for one item
   always_comb begin
      state_in = state_ff; phase_in = phase_ff; sp_in = sp_ff; nfn_in = nfn_ff;
      lbl_in = lbl_ff; acc_in = acc_ff; walk_in = walk_ff; child_in = child_ff;
      cur_in = cur_ff; root_in = root_ff; crc_in = crc_ff; err_in = err_ff;
      data_in = data_ff; cnt_in = cnt_ff; pend_v_in = pend_v_ff; pend_in = pend_ff;
      out_in = out_ff; q_pop = 1'b0;
      node_we = 1'b0; node_wa = '0; node_wd = '0; node_re = 1'b0; node_ra = '0;
      stk_we = 1'b0; stk_wa = '0; stk_wd = '0; stk_re = 1'b0; stk_ra = '0;

      out_free = !out_v_ff || !rsp_stall;
      out_v_in = out_v_ff && rsp_stall;
      bit_cur  = data_ff[3'(cnt_ff - 4'd1)];
      cnt_dec  = cnt_ff - 4'd1;
      acc_new  = {acc_ff[6:0], bit_cur};
      crc_upd  = crc_next(crc_ff, node_rd_ff[7:0]);
      after_bit = ST_FLUSH;

      case (state_ff)
         ST_FETCH: begin
            if (q_valid) begin
               q_pop = 1'b1;
               case (q_item.func)
                  FN_COMP, FN_RAW: begin
                     phase_in = (q_item.func == FN_COMP) ? PH_BUILD : PH_RAW;
                     sp_in = '0; nfn_in = '0; lbl_in = '0; acc_in = '0;
                     walk_in = '0; crc_in = '0;
                  end
                  FN_DATA: begin
                     data_in = q_item.data_byte;
                     cnt_in  = 4'd8;
                     case (phase_ff)
                        PH_RAW: begin
                           crc_in    = crc_next(crc_ff, q_item.data_byte);
                           pend_v_in = 1'b1;
                           pend_in   = '{q_item.data_byte, crc_next(crc_ff, q_item.data_byte),
                                         err_ff, 1'b0};
                           state_in  = ST_FLUSH;
                        end
                        PH_BUILD:  state_in = ST_BUILD;
                        PH_DECODE: state_in = ST_DEC;
                        default: ;
                     endcase
                  end
                  default: ;
               endcase
            end
         end

         // one bit of the pre-order tree code
         ST_BUILD: begin
            cnt_in    = cnt_dec;
            after_bit = (cnt_dec == 4'd0) ? ST_FLUSH : ST_BUILD;
            state_in  = after_bit;
            if (lbl_ff != 4'd0) begin
               acc_in = acc_new;
               lbl_in = lbl_ff - 4'd1;
               if (lbl_ff == 4'd1) begin
                  node_we = 1'b1;
                  node_wa = NODE_AW'(nfn_ff - 1'b1);
                  node_wd = {1'b1, 2'b00, acc_new};
                  if (sp_ff == '0) begin
                     if (nfn_ff == NFN_W'(1)) begin
                        // degenerate tree: root is a leaf
                        err_in = 1'b1; phase_in = PH_HALT;
                        pend_v_in = 1'b1; pend_in = '{8'h00, crc_ff, 1'b1, 1'b0};
                        state_in = ST_FLUSH;
                     end else begin
                        phase_in = PH_DECODE;
                        walk_in  = '0;
                        state_in = ST_ROOT;
                     end
                  end else begin
                     stk_re   = 1'b1;
                     stk_ra   = STK_AW'(sp_ff - 1'b1);
                     sp_in    = sp_ff - 1'b1;
                     state_in = ST_POP;
                  end
               end
            end else if (nfn_ff >= NFN_W'(NODE_COUNT) ||
                         (!bit_cur && sp_ff >= SP_W'(STACK_DEPTH))) begin
               // node store or stack overflow
               err_in = 1'b1; phase_in = PH_HALT;
               pend_v_in = 1'b1; pend_in = '{8'h00, crc_ff, 1'b1, 1'b0};
               state_in = ST_FLUSH;
            end else if (bit_cur) begin
               nfn_in = nfn_ff + 1'b1;
               lbl_in = 4'd8;
               acc_in = '0;
            end else begin
               node_we = 1'b1;
               node_wa = NODE_AW'(nfn_ff);
               node_wd = '0;
               stk_we  = 1'b1;
               stk_wa  = STK_AW'(sp_ff);
               stk_wd  = NODE_AW'(nfn_ff);
               sp_in   = sp_ff + 1'b1;
               nfn_in  = nfn_ff + 1'b1;
            end
         end

         // link the popped internal node to its second child, the next node to be made
         ST_POP: begin
            node_we  = 1'b1;
            node_wa  = stk_rd_ff;
            node_wd  = {1'b0, nfn_ff};
            state_in = (cnt_ff == 4'd0) ? ST_FLUSH : ST_BUILD;
         end

         ST_ROOT: begin
            node_re  = 1'b1;
            node_ra  = '0;
            state_in = ST_ROOT_WAIT;
         end

         ST_ROOT_WAIT: begin
            cur_in   = node_rd_ff;
            root_in  = node_rd_ff;
            state_in = (cnt_ff == 4'd0) ? ST_FLUSH : ST_DEC;
         end

         // walk one bit: fetch the chosen child
         ST_DEC: begin
            child_in = bit_cur ? cur_ff[NODE_AW-1:0] : walk_ff + 1'b1;
            node_re  = 1'b1;
            node_ra  = child_in;
            cnt_in   = cnt_dec;
            state_in = ST_DEC_CHK;
         end

         ST_DEC_CHK: begin
            after_bit = (cnt_ff == 4'd0) ? ST_FLUSH : ST_DEC;
            if (node_rd_ff[LEAF_POS]) begin
               if (!pend_v_ff || out_free) begin
                  if (pend_v_ff) begin
                     out_v_in = 1'b1;
                     out_in   = pend_ff;
                  end
                  crc_in    = crc_upd;
                  pend_v_in = 1'b1;
                  pend_in   = '{node_rd_ff[7:0], crc_upd, err_ff, 1'b0};
                  walk_in   = '0;
                  cur_in    = root_ff;
                  state_in  = after_bit;
               end
            end else begin
               walk_in  = child_ff;
               cur_in   = node_rd_ff;
               state_in = after_bit;
            end
         end

         // hand over the held result as the item's final one
         ST_FLUSH: begin
            if (!pend_v_ff) begin
               state_in = ST_FETCH;
            end else if (out_free) begin
               out_v_in  = 1'b1;
               out_in    = pend_ff;
               out_in.last = 1'b1;
               pend_v_in = 1'b0;
               state_in  = ST_FETCH;
            end
         end

         default: state_in = ST_FETCH;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_FETCH;
         phase_ff  <= PH_RAW;
         sp_ff     <= '0;
         nfn_ff    <= '0;
         lbl_ff    <= '0;
         acc_ff    <= '0;
         walk_ff   <= '0;
         crc_ff    <= '0;
         err_ff    <= 1'b0;
         cnt_ff    <= '0;
         pend_v_ff <= 1'b0;
         out_v_ff  <= 1'b0;
      end else begin
         state_ff  <= state_in;
         phase_ff  <= phase_in;
         sp_ff     <= sp_in;
         nfn_ff    <= nfn_in;
         lbl_ff    <= lbl_in;
         acc_ff    <= acc_in;
         walk_ff   <= walk_in;
         crc_ff    <= crc_in;
         err_ff    <= err_in;
         cnt_ff    <= cnt_in;
         pend_v_ff <= pend_v_in;
         out_v_ff  <= out_v_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      child_ff <= child_in;
      cur_ff   <= cur_in;
      root_ff  <= root_in;
      data_ff  <= data_in;
      pend_ff  <= pend_in;
      out_ff   <= out_in;
   end

   // node store and pending stack
   always_ff @(posedge clock) begin
      if (node_we) node_mem[node_wa] <= node_wd;
      if (node_re) node_rd_ff <= node_mem[node_ra];
   end

   always_ff @(posedge clock) begin
      if (stk_we) stk_mem[stk_wa] <= stk_wd;
      if (stk_re) stk_rd_ff <= stk_mem[stk_ra];
   end

   stack_in_range: assert property (@(posedge clock) disable iff (reset)
      sp_ff <= SP_W'(STACK_DEPTH)) else $error("stack pointer out of range");
   nodes_in_range: assert property (@(posedge clock) disable iff (reset)
      nfn_ff <= NFN_W'(NODE_COUNT)) else $error("node count out of range");
   fetch_with_nothing_held: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_FETCH |-> !pend_v_ff) else $error("result held across items");
   halt_sets_error: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_HALT |-> err_ff) else $error("halted without error flag");

endmodule
`default_nettype wire

>>> sv/huffman_tree_stream_decoder.sv
// huffman_tree_stream_decoder: top level joining the input queue and the decode core
// depends on hts_pkg, hts_front, hts_core
//
// Usage: items enter on req_valid/req_stall with req_item {func, data_byte}.
// func compressed-restart or raw-restart clears crc and drops partial state and
// gives no result; func data gives zero to eight results on rsp_valid/rsp_stall,
// the final one of an item marked by last. The unused code is taken and ignored.
// A raw byte passes the fetch and flush states: its result is held, then moved to
// the output register. A restart takes only the fetch state. A compressed byte is
// handled one bit at a time after the fetch: one build step per bit while the tree
// is built (plus one pop step per completed leaf with a pending parent, plus the
// root read and root wait steps once to load the root) and a child fetch and check
// step per bit while walking, set by the registered read of the node store for
// each child; a flush step hands over the final result. A two-entry queue sits
// in front so input can be taken while the core works. Results pass through an
// output register; while rsp_stall is high the core holds a further result and
// waits, and the queue fills until req_stall rises. Reset empties the queue,
// selects raw pass-through and clears crc and the error flag; no clearing pass is
// needed since node and stack contents are only read after being written.
`default_nettype none
module huffman_tree_stream_decoder (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire hts_pkg::req_type req_item,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output hts_pkg::rsp_type      rsp_item
);
   import hts_pkg::*;

   logic    q_valid, q_pop;
   req_type q_item;

   // input queue
   hts_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_item  (req_item),
      .q_valid   (q_valid),
      .q_item    (q_item),
      .q_pop     (q_pop)
   );

   // decode core
   hts_core u_core (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (q_valid),
      .q_item    (q_item),
      .q_pop     (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_item  (rsp_item)
   );

endmodule
`default_nettype wire

>>> test/hts_checker.sv
// hts_checker: watches both channels of the huffman stream decoder, predicts the
// decoded bytes with crc and error flag, and counts mismatches; depends on hts_pkg
`default_nettype none
module hts_checker (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   input  wire logic             req_stall,
   input  wire hts_pkg::req_type req_item,
   input  wire logic             rsp_valid,
   input  wire logic             rsp_stall,
   input  wire hts_pkg::rsp_type rsp_item,
   output int                    fail_count,
   output int                    pending_count,
   output int                    byte_count
);
   import hts_pkg::*;

   // predictor state
   logic [18:0] tree_mem [NODE_COUNT];
   logic [8:0]  parent_stack [STACK_DEPTH];
   int unsigned sp, nfn, bits_left, walk;
   logic [7:0]  leaf_acc;
   logic [15:0] crc;
   logic        err;
   phase_type   ph;
   rsp_type     expected_bytes [$];

   function automatic logic [15:0] crc_step(input logic [15:0] c0, input logic [7:0] b);
      logic [15:0] c;
      c = c0 ^ {b, 8'h00};
      for (int i = 0; i < 8; i++) c = c[15] ? ({c[14:0], 1'b0} ^ 16'h1021) : {c[14:0], 1'b0};
      return c;
   endfunction

   function automatic rsp_type make_byte(input logic [7:0] b);
      rsp_type r;
      r.out_byte = b; r.running_crc = crc; r.error = err; r.last = 1'b0;
      return r;
   endfunction

   // one tree-build bit, returns 1 on error
   function automatic bit tree_bit(input bit b);
      int unsigned idx;
      if (bits_left > 0) begin
         leaf_acc = {leaf_acc[6:0], b};
         bits_left--;
         if (bits_left != 0) return 1'b0;
         idx = (nfn - 1) % NODE_COUNT;
         tree_mem[idx] = {1'b1, 10'd0, leaf_acc};
         if (sp == 0) begin
            if (tree_mem[0][18]) return 1'b1;
            ph = PH_DECODE; walk = 0;
            return 1'b0;
         end
         sp--;
         tree_mem[parent_stack[sp % STACK_DEPTH]] = 19'(nfn & 10'h3ff);
         return 1'b0;
      end
      if (nfn >= NODE_COUNT) return 1'b1;
      if (b) begin
         nfn++; bits_left = 8; leaf_acc = '0;
      end else begin
         if (sp >= STACK_DEPTH) return 1'b1;
         tree_mem[nfn] = '0; parent_stack[sp] = nfn[8:0]; sp++; nfn++;
      end
      return 1'b0;
   endfunction

   task automatic predict_item(input req_type it);
      int n;
      int unsigned cur, child;
      bit b;
      rsp_type r;
      n = 0;
      if (it.func == FN_COMP || it.func == FN_RAW) begin
         ph = (it.func == FN_COMP) ? PH_BUILD : PH_RAW;
         sp = 0; nfn = 0; bits_left = 0; leaf_acc = '0; walk = 0; crc = '0;
         return;
      end
      if (it.func != FN_DATA) return;
      if (ph == PH_RAW) begin
         crc = crc_step(crc, it.data_byte);
         expected_bytes.push_back(make_byte(it.data_byte)); n++;
      end else begin
         for (int i = 7; i >= 0 && ph != PH_HALT; i--) begin
            b = it.data_byte[i];
            if (ph == PH_BUILD) begin
               if (tree_bit(b)) begin
                  err = 1'b1; ph = PH_HALT;
                  expected_bytes.push_back(make_byte(8'h00)); n++;
               end
            end else if (ph == PH_DECODE) begin
               cur = walk % NODE_COUNT;
               child = (b ? (tree_mem[cur] & 19'h3ff) : cur + 1) % NODE_COUNT;
               if (tree_mem[child][18]) begin
                  crc = crc_step(crc, tree_mem[child][7:0]);
                  expected_bytes.push_back(make_byte(tree_mem[child][7:0])); n++;
                  walk = 0;
               end else walk = child;
            end
         end
      end
      if (n > 0) begin
         r = expected_bytes.pop_back(); r.last = 1'b1; expected_bytes.push_back(r);
      end
   endtask

   // predict on accepted input, compare on accepted result
   always @(posedge clock) begin
      rsp_type e;
      int nf;
      nf = 0;
      if (reset) begin
         sp = 0; nfn = 0; bits_left = 0; leaf_acc = '0; walk = 0; crc = '0; err = 1'b0;
         ph = PH_RAW;
         foreach (tree_mem[i]) tree_mem[i] = '0;
         expected_bytes.delete();
         fail_count <= 0; byte_count <= 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            byte_count <= byte_count + 1;
            if (expected_bytes.size() == 0) begin
               $error("unexpected item %h", rsp_item);
               nf++;
            end else begin
               e = expected_bytes.pop_front();
               if (e.out_byte !== rsp_item.out_byte) begin
                  $error("out_byte expected %h actual %h", e.out_byte, rsp_item.out_byte);
                  nf++;
               end
               if (e.running_crc !== rsp_item.running_crc) begin
                  $error("running_crc expected %h actual %h", e.running_crc,
                         rsp_item.running_crc);
                  nf++;
               end
               if (e.error !== rsp_item.error) begin
                  $error("error expected %b actual %b", e.error, rsp_item.error);
                  nf++;
               end
               if (e.last !== rsp_item.last) begin
                  $error("last expected %b actual %b", e.last, rsp_item.last);
                  nf++;
               end
            end
            fail_count <= fail_count + nf;
         end
         if (req_valid && !req_stall) predict_item(req_item);
      end
      pending_count <= expected_bytes.size();
   end
endmodule
`default_nettype wire

>>> test/testbench.sv
// testbench: stimulus and verdict for the huffman stream decoder
// depends on hts_pkg, huffman_tree_stream_decoder and hts_checker
`default_nettype none
module testbench;
   import hts_pkg::*;

   logic    clock, reset, req_valid, req_stall, rsp_valid, rsp_stall;
   req_type req_item;
   rsp_type rsp_item;
   int      fail_count, pending_count, byte_count, cycle_count;
   int      send_idle_pct, recv_idle_pct, item_count;
   int      leftover_fails;

   huffman_tree_stream_decoder dut (.*);
   hts_checker checker_i (.*);

   initial begin
      clock = 0;
      forever #6 clock = ~clock;
   end

   // receiver stall and timeout
   always @(negedge clock) rsp_stall <= ($urandom_range(99) < recv_idle_pct);
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > 600000) begin
         $display("testbench NOT OK");
         $finish;
      end
   end

   // offer one item and hold it until accepted
   task automatic send_item(input logic [1:0] f, input logic [7:0] d);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 0;
         @(negedge clock);
      end
      req_valid <= 1; req_item <= '{func: f, data_byte: d};
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
      item_count++;
   endtask

   // compressed stream: tree code of given leaf count then random walk bytes
   task automatic send_tree_stream(input int leaves, input int walk_bytes);
      bit bits [$];
      logic [7:0] b;
      int need;
      send_item(FN_COMP, 8'($urandom));
      // right-leaning chain of internal nodes, each with a random-byte leaf on its left
      need = 1;
      for (int i = 0; i < leaves - 1; i++) begin
         bits.push_back(1'b0);
         bits.push_back(1'b1);
         for (int k = 0; k < 8; k++) bits.push_back(1'($urandom_range(1)));
      end
      bits.push_back(1'b1);
      for (int k = 0; k < 8; k++) bits.push_back(1'($urandom_range(1)));
      while (bits.size() % 8 != 0 && need > 0) bits.push_back(1'($urandom_range(1)));
      while (bits.size() > 0) begin
         for (int k = 7; k >= 0; k--) b[k] = (bits.size() > 0) ? bits.pop_front() : 1'b0;
         send_item(FN_DATA, b);
      end
      for (int i = 0; i < walk_bytes; i++) send_item(FN_DATA, 8'($urandom));
   endtask

   initial begin
      reset = 1; req_valid = 0; req_item = '0;
      item_count = 0; send_idle_pct = 0; recv_idle_pct = 0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 0;
      // directed: raw extremes, unused code, degenerate tree, halted data, tree build and decode, overflow
      send_item(FN_DATA, 8'h00);
      send_item(FN_DATA, 8'hff);
      send_item(FN_NONE, 8'h5a);
      send_item(FN_RAW, 8'h00);
      send_item(FN_DATA, 8'ha5);
      send_item(FN_COMP, 8'h00);
      send_item(FN_DATA, 8'hc3);
      send_item(FN_DATA, 8'h80);
      send_item(FN_DATA, 8'h11);
      send_item(FN_COMP, 8'hff);
      send_item(FN_DATA, 8'b0_1_000000);
      send_item(FN_DATA, 8'b01_1_11111);
      send_item(FN_DATA, 8'b111_00000);
      send_item(FN_DATA, 8'h00);
      send_item(FN_DATA, 8'hff);
      // tree completes mid-byte, then stack overflow from all-zero code
      send_tree_stream(3, 2);
      send_item(FN_COMP, 8'h00);
      for (int i = 0; i < 33; i++) send_item(FN_DATA, 8'h00);
      send_item(FN_DATA, 8'h00);
      // hold off until everything has drained
      req_valid <= 0;
      @(negedge clock);
      while (pending_count != 0) @(negedge clock);
      // random phases with idling profiles
      for (int p = 0; p < 3; p++) begin
         send_idle_pct = (p == 0) ? 22 : (p == 1) ? 54 : 0;
         recv_idle_pct = (p == 0) ? 54 : (p == 1) ? 22 : 0;
         for (int s = 0; s < 2; s++) begin
            case ($urandom_range(9))
               0: begin
                  send_item(FN_RAW, 8'($urandom));
                  repeat ($urandom_range(6)) send_item(FN_DATA, 8'($urandom));
               end
               1: send_item(2'($urandom_range(3)), 8'($urandom));
               default: send_tree_stream($urandom_range(2, 6), $urandom_range(2, 5));
            endcase
         end
      end
      req_valid <= 0;
      @(negedge clock);
      while (pending_count != 0) @(negedge clock);
      repeat (40) @(negedge clock);
      leftover_fails = fail_count + pending_count;
      $display("sent %0d items over raw, tree-build, decode and error paths", item_count);
      $display("checked %0d result items", byte_count);
      if (leftover_fails == 0) $display("testbench OK");
      else $display("testbench NOT OK");
      $finish;
   end
endmodule
`default_nettype wire
